[hdl/vtf_pkg.sv]
// Shared types and constants for the fixed-point vertex transform block.
package vtf_pkg;

  // Matrix geometry: a 4x4 matrix stored column-major.
  localparam int unsigned DIM     = 4;
  localparam int unsigned ENTRIES = DIM * DIM;
  localparam int unsigned IDX_W   = 4;

  // Signed 16.16 fixed-point word and its unit value.
  localparam int unsigned FIX_W   = 32;
  typedef logic signed [FIX_W-1:0] fix_t;
  localparam fix_t FIX_ONE = 32'sh0001_0000;

  // Fractional bits dropped from each full product.
  localparam int unsigned FRAC_W = 16;

  // Request function codes.
  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_XFORM = 1'b1
  } func_e;

  // One matrix entry write.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    fix_t             data;
  } mat_wr_t;

endpackage

[hdl/vtf_if.sv]
// Request and response channel interfaces of the vertex transform block.
interface vtf_req_if;
  logic                valid;
  logic                ready;
  logic                func;
  logic [3:0]          entry_index;
  logic signed [31:0]  entry_value;
  logic signed [31:0]  vec_x;
  logic signed [31:0]  vec_y;
  logic signed [31:0]  vec_z;
  logic signed [31:0]  vec_w;

  modport source (
    output valid, func, entry_index, entry_value, vec_x, vec_y, vec_z, vec_w,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, entry_value, vec_x, vec_y, vec_z, vec_w,
    output ready
  );
endinterface

interface vtf_rsp_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  out_x;
  logic signed [31:0]  out_y;
  logic signed [31:0]  out_z;
  logic signed [31:0]  out_w;

  modport source (
    output valid, out_x, out_y, out_z, out_w,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w,
    output ready
  );
endinterface

[hdl/vtf_matrix.sv]
// Matrix register file: sixteen 16.16 entries that reset to identity.
module vtf_matrix (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vtf_pkg::mat_wr_t wr_i,
  output vtf_pkg::fix_t    matrix_o [vtf_pkg::ENTRIES]
);

  vtf_pkg::fix_t matrix_q [vtf_pkg::ENTRIES];

  // Each entry is its own register; diagonal entries reset to one.
  for (genvar e = 0; e < vtf_pkg::ENTRIES; e++) begin : g_entry
    localparam bit IsDiag = ((e / vtf_pkg::DIM) == (e % vtf_pkg::DIM));
    localparam vtf_pkg::fix_t ResetVal = IsDiag ? vtf_pkg::FIX_ONE : '0;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        matrix_q[e] <= ResetVal;
      end else if (wr_i.en && (wr_i.idx == vtf_pkg::IDX_W'(e))) begin
        matrix_q[e] <= wr_i.data;
      end
    end

    assign matrix_o[e] = matrix_q[e];
  end

  // A write lands in the addressed entry on the next cycle.
  a_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.en |=> matrix_q[$past(wr_i.idx)] == $past(wr_i.data))
    else $error("matrix write did not reach the addressed entry");

endmodule

[hdl/vtf_product.sv]
// First pipeline stage: sixteen 32x32 products, scaled back to 16.16.
module vtf_product (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  vtf_pkg::fix_t vec_i    [vtf_pkg::DIM],
  input  vtf_pkg::fix_t matrix_i [vtf_pkg::ENTRIES],
  output logic          valid_o,
  input  logic          ready_i,
  output vtf_pkg::fix_t prod_o   [vtf_pkg::ENTRIES]
);

  logic          valid_q;
  vtf_pkg::fix_t prod_d [vtf_pkg::ENTRIES];
  vtf_pkg::fix_t prod_q [vtf_pkg::ENTRIES];
  logic          adv;

  // The stage moves when it is empty or its content is taken downstream.
  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;

  // Entry column*4+row multiplies vector component number column.
  for (genvar e = 0; e < vtf_pkg::ENTRIES; e++) begin : g_mul
    logic signed [2*vtf_pkg::FIX_W-1:0] full;
    assign full = matrix_i[e] * vec_i[e / vtf_pkg::DIM];
    assign prod_d[e] = full[vtf_pkg::FRAC_W +: vtf_pkg::FIX_W];
  end

  // Valid bit of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  // Product registers.
  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

  // An item taken in shows up as valid on the next cycle.
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && adv) |=> valid_q)
    else $error("product stage lost an item");

endmodule

[hdl/vtf_adder_tree.sv]
// Second and third pipeline stages: pairwise row sums, then final sums.
module vtf_adder_tree (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  vtf_pkg::fix_t prod_i [vtf_pkg::ENTRIES],
  vtf_rsp_if.source     rsp_o
);

  localparam int unsigned Pairs = 2 * vtf_pkg::DIM;

  logic          s2_valid_q;
  vtf_pkg::fix_t s2_sum_q [Pairs];
  logic          s3_valid_q;
  vtf_pkg::fix_t s3_sum_q [vtf_pkg::DIM];
  logic          s2_adv;
  logic          s3_adv;

  // Each stage moves when empty or when the next one moves.
  assign s3_adv  = !s3_valid_q || rsp_o.ready;
  assign s2_adv  = !s2_valid_q || s3_adv;
  assign ready_o = s2_adv;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s2_adv) begin
        s2_valid_q <= valid_i;
      end
      if (s3_adv) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // Row r: columns 0+1 and columns 2+3 are summed first, wrapping at 32 bits.
  for (genvar r = 0; r < vtf_pkg::DIM; r++) begin : g_row
    always_ff @(posedge clk_i) begin
      if (s2_adv && valid_i) begin
        s2_sum_q[2*r]   <= prod_i[r] + prod_i[vtf_pkg::DIM + r];
        s2_sum_q[2*r+1] <= prod_i[2*vtf_pkg::DIM + r] + prod_i[3*vtf_pkg::DIM + r];
      end
      if (s3_adv && s2_valid_q) begin
        s3_sum_q[r] <= s2_sum_q[2*r] + s2_sum_q[2*r+1];
      end
    end
  end

  assign rsp_o.valid = s3_valid_q;
  assign rsp_o.out_x = s3_sum_q[0];
  assign rsp_o.out_y = s3_sum_q[1];
  assign rsp_o.out_z = s3_sum_q[2];
  assign rsp_o.out_w = s3_sum_q[3];

  // A full middle stage with room ahead always moves into the output stage.
  a_mid_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s3_adv) |=> s3_valid_q)
    else $error("partial sums did not reach the output stage");

  // A waiting result keeps its sums; the x and w sums are checked.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && !rsp_o.ready) |=> $stable(s3_sum_q[0]) && $stable(s3_sum_q[3]))
    else $error("output sums changed while stalled");

endmodule

[hdl/vertex_transform_fixed.sv]
// Top level of the fixed-point 4x4 matrix times vector transform.
// The block keeps a column-major 4x4 matrix of signed 16.16 values, identity
// after reset. A load request writes one entry and returns nothing; a transform
// request returns M*(x,y,z,w), each product taken as bits 47:16 of the full
// signed product and each sum wrapping at 32 bits. One request is taken every
// cycle whenever the output side keeps up. Three register stages lie between a
// request and its result: the sixteen parallel multipliers, the first level of
// adds and the final adds held in the output register. A load takes effect for
// the very next request.
module vertex_transform_fixed (
  input  logic      clk_i,
  input  logic      rst_ni,
  vtf_req_if.sink   req_i,
  vtf_rsp_if.source rsp_o
);

  vtf_pkg::fix_t    matrix [vtf_pkg::ENTRIES];
  vtf_pkg::fix_t    vec    [vtf_pkg::DIM];
  vtf_pkg::fix_t    prod   [vtf_pkg::ENTRIES];
  vtf_pkg::mat_wr_t mat_wr;
  logic             prod_ready;
  logic             prod_valid;
  logic             tree_ready;
  logic             is_xform;
  logic             req_acc;

  // Requests are taken whenever the product stage can move.
  assign req_i.ready = prod_ready;
  assign req_acc     = req_i.valid && prod_ready;
  assign is_xform    = (req_i.func == vtf_pkg::FUNC_XFORM);

  // A taken load request writes the matrix and enters no stage.
  assign mat_wr.en   = req_acc && !is_xform;
  assign mat_wr.idx  = req_i.entry_index;
  assign mat_wr.data = req_i.entry_value;

  assign vec[0] = req_i.vec_x;
  assign vec[1] = req_i.vec_y;
  assign vec[2] = req_i.vec_z;
  assign vec[3] = req_i.vec_w;

  vtf_matrix u_matrix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (mat_wr),
    .matrix_o (matrix)
  );

  vtf_product u_product (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (req_i.valid && is_xform),
    .ready_o  (prod_ready),
    .vec_i    (vec),
    .matrix_i (matrix),
    .valid_o  (prod_valid),
    .ready_i  (tree_ready),
    .prod_o   (prod)
  );

  vtf_adder_tree u_adder_tree (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (tree_ready),
    .prod_i  (prod),
    .rsp_o   (rsp_o)
  );

  // A load request never puts an item into the pipeline.
  a_load_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && !is_xform) |=> !prod_valid)
    else $error("load request produced a pipeline item");

endmodule
